[design/ulve_pkg.sv]
// Shared codes and types for the unique value list engine.
`default_nettype none

package ulve_pkg;

	localparam logic [2:0] M_BUILD  = 3'd0;
	localparam logic [2:0] M_APPEND = 3'd1;
	localparam logic [2:0] M_DELETE = 3'd2;
	localparam logic [2:0] M_MAX    = 3'd3;
	localparam logic [2:0] M_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BUILT    = 3'd5;

	typedef struct packed {
		logic clear;
		logic vld;
		logic first;
	} scan_ctl_t;

endpackage

`default_nettype wire

[design/ulve_scan.sv]
// Shared compare unit: duplicate match and running signed maximum over a read stream.
`default_nettype none

module ulve_scan import ulve_pkg::*; #(
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scan_ctl_t     ctl,
	input  wire logic [31:0]   data,
	input  wire logic [AW-1:0] idx,
	input  wire logic [31:0]   key,
	output logic               hit,
	output logic [31:0]        max_val,
	output logic [AW-1:0]      max_idx
);

	logic          hit_q;
	logic [31:0]   max_q;
	logic [AW-1:0] midx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.vld && (data == key)) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && (ctl.first || ($signed(data) > $signed(max_q)))) begin
			max_q  <= data;
			midx_q <= idx;
		end
	end

	assign hit     = hit_q;
	assign max_val = max_q;
	assign max_idx = midx_q;

endmodule

`default_nettype wire

[design/unique_value_list_engine_unit.sv]
// Ordered list of signed values with build-prepend, unique append, delete, max query, clear.
// The walk reads one entry a cycle; flagged, clear, build-end and unused-mode beats skip the walk.
// Max and append scan the list; prepend scans, then shifts up; delete shifts the entries after
// position down. Next beat taken as out_valid rises.
// Reset clears count, build and repeat flags; entry store contents are undefined and
// are never read above count, so no clearing pass is run.
`default_nettype none

module unique_value_list_engine_unit import ulve_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         mode,
	input  wire logic signed [31:0] value,
	input  wire logic [7:0]         position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic signed [31:0]      max_value,
	output logic [3:0]              max_index,
	output logic [4:0]              entry_count
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = $clog2(MAX_ENTRIES);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_SHUP = 5'b00100,
		S_SHDN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          building_q;
	logic          repeat_q;
	logic [2:0]    mode_q;
	logic [31:0]   val_q;
	logic [CW-1:0] rd_q;
	logic [2:0]    res_status_q;
	logic          res_max_q;

	logic [31:0]   mem [MAX_ENTRIES];
	logic [31:0]   rdata_s1;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [31:0]   max_value_q;
	logic [3:0]    max_index_q;
	logic [4:0]    entry_count_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          accept;
	logic          full;
	logic          walk_done;
	logic          out_free;
	scan_ctl_t     scan_ctl;
	logic          hit;
	logic [31:0]   scan_max;
	logic [AW-1:0] scan_idx;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign full     = (count_q >= CW'(MAX_ENTRIES));
	assign out_free = !out_valid_q || out_ready;

	// read issue
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_q[AW-1:0];
		unique case (state_q)
			S_SCAN, S_SHDN: begin
				rd_en = (rd_q < count_q);
			end
			S_SHUP: begin
				rd_en   = (rd_q != '0);
				rd_addr = AW'(rd_q - CW'(1));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign walk_done = !rd_en && !vld_s1;

	// write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rdata_s1;
		unique case (state_q)
			S_SHUP: begin
				if (vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = AW'(idx_s1 + AW'(1));
				end else if (rd_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = val_q;
				end
			end
			S_SHDN: begin
				wr_en   = vld_s1;
				wr_addr = AW'(idx_s1 - AW'(1));
			end
			S_SCAN: begin
				if (walk_done && (mode_q == M_APPEND) && !hit && !full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = val_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= rd_en;
			idx_s1 <= rd_addr;
		end
	end

	assign scan_ctl.clear = accept;
	assign scan_ctl.vld   = vld_s1 && (state_q == S_SCAN);
	assign scan_ctl.first = (idx_s1 == '0);

	ulve_scan #(
		.AW(AW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.data    (rdata_s1),
		.idx     (idx_s1),
		.key     (val_q),
		.hit     (hit),
		.max_val (scan_max),
		.max_idx (scan_idx)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			building_q   <= 1'b0;
			repeat_q     <= 1'b0;
			mode_q       <= M_BUILD;
			val_q        <= '0;
			rd_q         <= '0;
			res_status_q <= ST_OK;
			res_max_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q       <= mode;
						val_q        <= value;
						res_status_q <= ST_OK;
						res_max_q    <= 1'b0;
						rd_q         <= '0;
						state_q      <= S_FIN;
						unique case (mode)
							M_BUILD: begin
								if ((count_q != '0) && !building_q) begin
									res_status_q <= ST_BUILT;
								end else if (value == '0) begin
									if (repeat_q) begin
										count_q      <= '0;
										res_status_q <= ST_DUP;
									end
									building_q <= 1'b0;
									repeat_q   <= 1'b0;
								end else begin
									building_q <= 1'b1;
									if (full) begin
										res_status_q <= ST_FULL;
									end else begin
										state_q <= S_SCAN;
									end
								end
							end
							M_APPEND, M_MAX: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							M_DELETE: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else if (9'(position) >= 9'(count_q)) begin
									res_status_q <= ST_NOTFOUND;
								end else begin
									rd_q    <= CW'(9'(position) + 9'd1);
									state_q <= S_SHDN;
								end
							end
							M_CLEAR: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									count_q <= '0;
								end
								building_q <= 1'b0;
								repeat_q   <= 1'b0;
							end
							default: begin
								res_status_q <= ST_OK;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_q <= rd_q + CW'(1);
					end else if (!vld_s1) begin
						state_q <= S_FIN;
						unique case (mode_q)
							M_BUILD: begin
								if (hit) begin
									repeat_q <= 1'b1;
								end
								rd_q    <= count_q;
								state_q <= S_SHUP;
							end
							M_APPEND: begin
								if (hit) begin
									res_status_q <= ST_DUP;
								end else if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							default: begin
								res_max_q <= 1'b1;
							end
						endcase
					end
				end
				S_SHUP: begin
					if (rd_en) begin
						rd_q <= rd_q - CW'(1);
					end else if (!vld_s1) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SHDN: begin
					if (rd_en) begin
						rd_q <= rd_q + CW'(1);
					end else if (!vld_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			status_q      <= res_status_q;
			max_value_q   <= res_max_q ? scan_max : 32'd0;
			max_index_q   <= res_max_q ? 4'(scan_idx) : 4'd0;
			entry_count_q <= 5'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign max_value   = max_value_q;
	assign max_index   = max_index_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_repeat_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		repeat_q |-> building_q)
		else $error("repeat flag set with no build open");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready straight after an accepted beat");

	a_max_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (max_value == 32'sd0))
		else $error("max value on a flagged result");

endmodule

`default_nettype wire

[dv/ulve_list_checker.sv]
// Checker for the unique value list engine: mirrors the list and compares every result beat.
module ulve_list_checker import ulve_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [2:0]         mode,
	input  wire logic signed [31:0] value,
	input  wire logic [7:0]         position,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [2:0]         status,
	input  wire logic signed [31:0] max_value,
	input  wire logic [3:0]         max_index,
	input  wire logic [4:0]         entry_count,
	output int                      errors,
	output int                      pending,
	output int                      checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] max_value;
		logic [3:0]         max_index;
		logic [4:0]         entry_count;
	} list_result_t;

	logic signed [31:0] list_vals [MAX_ENTRIES];
	int                 list_len;
	logic               build_open;
	logic               repeat_flag;
	list_result_t       expected_q [$];
	list_result_t       want;

	function automatic logic holds(input logic signed [31:0] v);
		for (int i = 0; i < list_len; i++) begin
			if (list_vals[i] == v)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic list_result_t apply_op(input logic [2:0] m, input logic signed [31:0] v,
			input logic [7:0] p);
		list_result_t       r;
		logic signed [31:0] best;
		int                 best_idx;
		r = '0;
		r.status = ST_OK;
		case (m)
			M_BUILD: begin
				if (list_len != 0 && !build_open) begin
					r.status = ST_BUILT;
				end else if (v == 0) begin
					// closing beat: a repeat seen during the build discards the lot
					if (repeat_flag) begin
						list_len = 0;
						r.status = ST_DUP;
					end
					build_open = 1'b0;
					repeat_flag = 1'b0;
				end else begin
					build_open = 1'b1;
					if (list_len >= MAX_ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						if (holds(v))
							repeat_flag = 1'b1;
						for (int i = list_len; i > 0; i--)
							list_vals[i] = list_vals[i - 1];
						list_vals[0] = v;
						list_len++;
					end
				end
			end
			M_APPEND: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (holds(v))
					r.status = ST_DUP;
				else if (list_len >= MAX_ENTRIES)
					r.status = ST_FULL;
				else begin
					list_vals[list_len] = v;
					list_len++;
				end
			end
			M_DELETE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(p) >= list_len) begin
					r.status = ST_NOTFOUND;
				end else begin
					for (int i = int'(p); i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
			M_MAX: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					best = list_vals[0];
					best_idx = 0;
					for (int i = 1; i < list_len; i++) begin
						if (list_vals[i] > best) begin
							best = list_vals[i];
							best_idx = i;
						end
					end
					r.max_value = best;
					r.max_index = best_idx[3:0];
				end
			end
			M_CLEAR: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else
					list_len = 0;
				build_open = 1'b0;
				repeat_flag = 1'b0;
			end
			default: ;
		endcase
		r.entry_count = list_len[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			build_open = 1'b0;
			repeat_flag = 1'b0;
			expected_q.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result beat: status %0d count %0d", status, entry_count);
					errors++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (status !== want.status) begin
						$error("status expected %0d got %0d", want.status, status);
						errors++;
					end
					if (max_value !== want.max_value) begin
						$error("max_value expected %0d got %0d", want.max_value, max_value);
						errors++;
					end
					if (max_index !== want.max_index) begin
						$error("max_index expected %0d got %0d", want.max_index, max_index);
						errors++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count expected %0d got %0d", want.entry_count,
							entry_count);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(apply_op(mode, value, position));
			pending <= expected_q.size();
		end
	end

endmodule

[dv/tb.sv]
// Testbench top for the unique value list engine: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ulve_pkg::*;

	localparam int RANDOM_OPS     = 750;
	localparam int WATCHDOG_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         mode = '0;
	logic signed [31:0] value = '0;
	logic [7:0]         position = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] max_value;
	logic [3:0]         max_index;
	logic [4:0]         entry_count;

	int fail_total;
	int awaiting;
	int results_seen;
	int idle_cycles = 0;
	int sent = 0;
	int op_tally [8];
	logic calm_tx = 1'b0;
	logic calm_rx = 1'b0;

	unique_value_list_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .value(value), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .max_value(max_value), .max_index(max_index),
		.entry_count(entry_count)
	);

	ulve_list_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .value(value), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .max_value(max_value), .max_index(max_index),
		.entry_count(entry_count),
		.errors(fail_total), .pending(awaiting), .checked(results_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("unique_value_list_engine_unit verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side: a fresh random stall, which may be zero, before every beat
	initial begin
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			stall = calm_rx ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	function automatic logic signed [31:0] pick_val(input logic narrow);
		return narrow ? 32'($urandom_range(0, 8)) - 32'sd4 : $urandom;
	endfunction

	function automatic logic [7:0] pick_pos();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
	endfunction

	task automatic send_op(input logic [2:0] m, input logic signed [31:0] v, input logic [7:0] p);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		position <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		op_tally[m]++;
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int scenario;
		logic narrow;
		foreach (op_tally[i])
			op_tally[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list answers
		send_op(M_MAX, 32'sd0, 8'd0);
		send_op(M_APPEND, 32'sd9, 8'd0);
		send_op(M_DELETE, 32'sd0, 8'd0);
		send_op(M_CLEAR, 32'sd0, 8'd0);
		send_op(M_BUILD, 32'sd0, 8'd0);
		// build with extremes, other ops while open
		send_op(M_BUILD, 32'sh7FFF_FFFF, 8'd0);
		send_op(M_BUILD, 32'sh8000_0000, 8'd0);
		send_op(M_BUILD, -32'sd1, 8'd255);
		send_op(M_BUILD, 32'sd1, 8'd0);
		send_op(M_APPEND, 32'sd42, 8'd0);
		send_op(M_MAX, 32'sd0, 8'd0);
		send_op(M_BUILD, 32'sd0, 8'd0);
		send_op(M_BUILD, 32'sd5, 8'd0);
		send_op(M_APPEND, -32'sd1, 8'd0);
		send_op(M_DELETE, 32'sd0, 8'd255);
		send_op(M_DELETE, 32'sd0, 8'd0);
		send_op(M_DELETE, 32'sd0, 8'd3);
		send_op(3'd5, 32'sh5A5A_A5A5, 8'hAA);
		send_op(3'd7, -32'sd1, 8'hFF);
		send_op(M_CLEAR, 32'sd0, 8'd0);
		// repeat during a build discards the list
		send_op(M_BUILD, 32'sd7, 8'd0);
		send_op(M_BUILD, 32'sd7, 8'd0);
		send_op(3'd6, 32'sd0, 8'd0);
		send_op(M_BUILD, 32'sd0, 8'd0);
		drain();

		n = sent;
		while (sent < n + RANDOM_OPS) begin
			calm_tx = ($urandom_range(0, 5) == 0);
			calm_rx = ($urandom_range(0, 5) == 0);
			narrow = ($urandom_range(0, 3) == 0);
			scenario = $urandom_range(0, 9);
			case (scenario)
				0, 1, 2, 3: begin
					if ($urandom_range(0, 3) != 0)
						send_op(M_CLEAR, pick_val(1'b0), pick_pos());
					repeat ($urandom_range(1, 18))
						send_op(M_BUILD, pick_val(narrow), pick_pos());
					if ($urandom_range(0, 4) != 0)
						send_op(M_BUILD, 32'sd0, pick_pos());
				end
				4, 5, 6: begin
					repeat ($urandom_range(1, 10))
						send_op(3'($urandom_range(1, 3)), pick_val(narrow), pick_pos());
				end
				7: begin
					// fill toward the brim by appending
					send_op(M_CLEAR, pick_val(1'b0), pick_pos());
					send_op(M_BUILD, pick_val(1'b0) | 32'sd1, pick_pos());
					send_op(M_BUILD, 32'sd0, pick_pos());
					repeat ($urandom_range(14, 18))
						send_op(M_APPEND, pick_val(1'b0), pick_pos());
				end
				8: begin
					repeat ($urandom_range(1, 5))
						send_op(3'($urandom), pick_val(narrow), 8'($urandom));
				end
				default: drain();
			endcase
		end

		drain();
		repeat (40) @(posedge clk);
		$display("%0d beats sent: build %0d, append %0d, delete %0d, max %0d, clear %0d, other %0d",
			sent, op_tally[M_BUILD], op_tally[M_APPEND], op_tally[M_DELETE], op_tally[M_MAX],
			op_tally[M_CLEAR], op_tally[5] + op_tally[6] + op_tally[7]);
		$display("%0d result beats compared, %0d mismatches", results_seen, fail_total);
		if (fail_total == 0)
			$display("unique_value_list_engine_unit verification clean");
		else
			$display("unique_value_list_engine_unit verification failed");
		$finish;
	end

endmodule
